@@ rtl/assert_macros.svh @@
// Assertion macros used by the array list engine sequencer.
// Taken in by `include; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock, off while reset is held.
`define ALIST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition now implies outcome on the next clock, off while reset is held.
`define ALIST_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/alist_pkg.sv @@
// Shared types and constants of the array list engine.
// No dependencies.
package alist_pkg;

    localparam int KIND_W     = 3;
    localparam int POS_W      = 8;
    localparam int VALUE_W    = 32;
    localparam int RDV_W      = 32;
    localparam int COUNT_W    = 9;
    localparam int STATUS_W   = 2;

    localparam int DEF_CAPACITY   = 256;
    localparam int DEF_DATA_WIDTH = 32;

    typedef enum logic [KIND_W-1:0] {
        K_READ    = 3'd0,
        K_WRITE   = 3'd1,
        K_INSERT  = 3'd2,
        K_REMOVE  = 3'd3,
        K_PUSH    = 3'd4,
        K_POP     = 3'd5,
        K_REVERSE = 3'd6,
        K_CLEAR   = 3'd7
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [RDV_W-1:0]   read_value;
        logic [COUNT_W-1:0] count;
        t_status            status;
    } t_rsp;

endpackage

@@ rtl/alist_req_if.sv @@
// Request channel of the array list engine: valid/ready plus request word.
// Depends on alist_pkg.
interface alist_req_if;
    logic                          valid;
    logic                          ready;
    logic [alist_pkg::KIND_W-1:0]  kind;
    logic [alist_pkg::POS_W-1:0]   position;
    logic [alist_pkg::VALUE_W-1:0] value;

    modport source (output valid, kind, position, value, input ready);
    modport sink   (input valid, kind, position, value, output ready);
endinterface

@@ rtl/alist_rsp_if.sv @@
// Response channel of the array list engine: valid/ready plus result word.
// Depends on alist_pkg.
interface alist_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [alist_pkg::RDV_W-1:0]    read_value;
    logic [alist_pkg::COUNT_W-1:0]  count;
    logic [alist_pkg::STATUS_W-1:0] status;

    modport source (output valid, read_value, count, status, input ready);
    modport sink   (input valid, read_value, count, status, output ready);
endinterface

@@ rtl/alist_mem.sv @@
// Element store: one write port, two registered read ports.
// No package dependencies.
module alist_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ rtl/alist_seq.sv @@
// Request sequencer: decodes a request, walks the element store for
// shifts and reversal, keeps the live count. Depends on alist_pkg.
`include "assert_macros.svh"

module alist_seq #(
    parameter int CAPACITY   = alist_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = alist_pkg::DEF_DATA_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  alist_pkg::t_req             i_req,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output alist_pkg::t_rsp             o_res,
    output logic                        o_mem_we,
    output logic [$clog2(CAPACITY)-1:0] o_mem_waddr,
    output logic [DATA_WIDTH-1:0]       o_mem_wdata,
    output logic [$clog2(CAPACITY)-1:0] o_mem_raddr_a,
    output logic [$clog2(CAPACITY)-1:0] o_mem_raddr_b,
    input  logic [DATA_WIDTH-1:0]       i_mem_rdata_a,
    input  logic [DATA_WIDTH-1:0]       i_mem_rdata_b
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int AW1  = AW + 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > alist_pkg::POS_W) ? CW : alist_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDWAIT,
        S_SHIFT_UP,
        S_PUT,
        S_SHIFT_DN,
        S_REV_WLO,
        S_REV_WHI,
        S_DONE
    } t_state;

    t_state             r_state,  n_state;
    logic [CW-1:0]      r_count,  n_count;
    logic [AW-1:0]      r_pos,    n_pos;
    logic [AW-1:0]      r_ptr,    n_ptr;    // walking pointer, low end on reverse
    logic [AW-1:0]      r_hi,     n_hi;     // high end on reverse
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [DATA_WIDTH-1:0] r_rd,  n_rd;
    logic [DATA_WIDTH-1:0] r_tmp, n_tmp;
    alist_pkg::t_status r_st,     n_st;

    logic [CMPW-1:0]    pos_c;
    logic [CMPW-1:0]    cnt_c;
    logic [CW-1:0]      cnt_m1;
    logic               full;
    logic               empty;
    logic [63:0]        val_ext;
    logic [DATA_WIDTH-1:0] in_val;
    logic [AW-1:0]      in_pos;
    logic [63:0]        rd_ext;
    logic [31:0]        cnt_ext;

    assign pos_c   = CMPW'(i_req.position);
    assign cnt_c   = CMPW'(r_count);
    assign cnt_m1  = r_count - 1'b1;
    assign full    = (r_count == CW'(CAPACITY));
    assign empty   = (r_count == '0);
    assign val_ext = 64'(i_req.value);
    assign in_val  = val_ext[DATA_WIDTH-1:0];
    assign in_pos  = AW'(i_req.position);
    assign rd_ext  = 64'(r_rd);
    assign cnt_ext = 32'(r_count);

    assign o_res.read_value = rd_ext[alist_pkg::RDV_W-1:0];
    assign o_res.count      = cnt_ext[alist_pkg::COUNT_W-1:0];
    assign o_res.status     = r_st;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_pos   = r_pos;
        n_ptr   = r_ptr;
        n_hi    = r_hi;
        n_val   = r_val;
        n_rd    = r_rd;
        n_tmp   = r_tmp;
        n_st    = r_st;

        o_req_ready   = (r_state == S_IDLE);
        o_res_valid   = 1'b0;
        o_mem_we      = 1'b0;
        o_mem_waddr   = r_ptr;
        o_mem_wdata   = i_mem_rdata_a;
        o_mem_raddr_a = r_ptr;
        o_mem_raddr_b = r_hi;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_rd    = '0;
                    n_st    = alist_pkg::ST_OK;
                    n_pos   = in_pos;
                    n_val   = in_val;
                    n_state = S_DONE;
                    case (alist_pkg::t_kind'(i_req.kind))
                        alist_pkg::K_READ: begin
                            if (pos_c < cnt_c) begin
                                o_mem_raddr_a = in_pos;
                                n_state       = S_RDWAIT;
                            end else begin
                                n_st = alist_pkg::ST_RANGE;
                            end
                        end
                        alist_pkg::K_WRITE: begin
                            if (pos_c < cnt_c) begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = in_pos;
                                o_mem_wdata = in_val;
                            end else begin
                                n_st = alist_pkg::ST_RANGE;
                            end
                        end
                        alist_pkg::K_INSERT: begin
                            if (full) begin
                                n_st = alist_pkg::ST_FULL;
                            end else if (pos_c > cnt_c) begin
                                n_st = alist_pkg::ST_RANGE;
                            end else if (pos_c == cnt_c) begin
                                // append at the end, nothing to move
                                o_mem_we    = 1'b1;
                                o_mem_waddr = in_pos;
                                o_mem_wdata = in_val;
                                n_count     = r_count + 1'b1;
                            end else begin
                                o_mem_raddr_a = AW'(cnt_m1);
                                n_ptr         = AW'(cnt_m1);
                                n_state       = S_SHIFT_UP;
                            end
                        end
                        alist_pkg::K_REMOVE: begin
                            if (empty) begin
                                n_st = alist_pkg::ST_EMPTY;
                            end else if (pos_c >= cnt_c) begin
                                n_st = alist_pkg::ST_RANGE;
                            end else if (pos_c == CMPW'(cnt_m1)) begin
                                n_count = cnt_m1;
                            end else begin
                                o_mem_raddr_a = in_pos + 1'b1;
                                n_ptr         = in_pos + 1'b1;
                                n_state       = S_SHIFT_DN;
                            end
                        end
                        alist_pkg::K_PUSH: begin
                            if (full) begin
                                n_st = alist_pkg::ST_FULL;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = AW'(r_count);
                                o_mem_wdata = in_val;
                                n_count     = r_count + 1'b1;
                            end
                        end
                        alist_pkg::K_POP: begin
                            if (empty) begin
                                n_st = alist_pkg::ST_EMPTY;
                            end else begin
                                n_count = cnt_m1;
                            end
                        end
                        alist_pkg::K_REVERSE: begin
                            if (r_count > CW'(1)) begin
                                o_mem_raddr_a = '0;
                                o_mem_raddr_b = AW'(cnt_m1);
                                n_ptr         = '0;
                                n_hi          = AW'(cnt_m1);
                                n_state       = S_REV_WLO;
                            end
                        end
                        alist_pkg::K_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_count = '0;
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                n_rd    = i_mem_rdata_a;
                n_state = S_DONE;
            end
            S_SHIFT_UP: begin
                // element at r_ptr moves one place up
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ptr + 1'b1;
                o_mem_wdata = i_mem_rdata_a;
                if (r_ptr == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    o_mem_raddr_a = r_ptr - 1'b1;
                    n_ptr         = r_ptr - 1'b1;
                end
            end
            S_PUT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_pos;
                o_mem_wdata = r_val;
                n_count     = r_count + 1'b1;
                n_state     = S_DONE;
            end
            S_SHIFT_DN: begin
                // element at r_ptr moves one place down
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ptr - 1'b1;
                o_mem_wdata = i_mem_rdata_a;
                if (CW'(r_ptr) == cnt_m1) begin
                    n_count = cnt_m1;
                    n_state = S_DONE;
                end else begin
                    o_mem_raddr_a = r_ptr + 1'b1;
                    n_ptr         = r_ptr + 1'b1;
                end
            end
            S_REV_WLO: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ptr;
                o_mem_wdata = i_mem_rdata_b;
                n_tmp       = i_mem_rdata_a;
                n_state     = S_REV_WHI;
            end
            S_REV_WHI: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_hi;
                o_mem_wdata = r_tmp;
                if ((AW1'(r_ptr) + AW1'(2)) < AW1'(r_hi)) begin
                    // next pair read while the high end is written
                    o_mem_raddr_a = r_ptr + 1'b1;
                    o_mem_raddr_b = r_hi - 1'b1;
                    n_ptr         = r_ptr + 1'b1;
                    n_hi          = r_hi - 1'b1;
                    n_state       = S_REV_WLO;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos <= n_pos;
        r_ptr <= n_ptr;
        r_hi  <= n_hi;
        r_val <= n_val;
        r_rd  <= n_rd;
        r_tmp <= n_tmp;
        r_st  <= n_st;
    end

    `ALIST_ASSERT(a_count_cap, i_clk, i_rst_n, r_count <= CW'(CAPACITY), "live count above capacity")
    `ALIST_ASSERT_NEXT(a_put_grows, i_clk, i_rst_n, r_state == S_PUT, r_count == $past(r_count) + 1'b1, "insert did not grow count")
    `ALIST_ASSERT(a_up_bound, i_clk, i_rst_n, (r_state == S_SHIFT_UP) |-> ((r_ptr >= r_pos) && (CW'(r_ptr) < r_count)), "shift-up pointer out of window")
    `ALIST_ASSERT(a_rev_order, i_clk, i_rst_n, (r_state == S_REV_WLO) |-> (r_ptr < r_hi), "reverse pointers crossed")

endmodule

@@ rtl/array_list_engine.sv @@
// Top level of the array list engine: sequencer, element store, result register.
// Depends on alist_pkg, alist_req_if, alist_rsp_if, alist_mem, alist_seq.
//
//  channel   dir  word fields                      handshake
//  i_req     in   kind, position, value            valid & ready
//  o_rsp     out  read_value, count, status        valid & ready
//
// Path of a request from accept to result: write, push, pop, clear and rejected
//   requests go straight to the result state; read passes through a read wait state.
//   Insert inside the list shifts elements up from the end, then puts the value;
//   remove inside the list shifts elements down; reverse swaps pairs from both ends.
//   These walks are set by the single write port of the element memory: one element moves per cycle.
// Reset clears the live count and control; store contents stay undefined.
// A result waits in the output register while a new request is taken; the
// sequencer holds its next result until that register drains.
module array_list_engine #(
    parameter int CAPACITY   = alist_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = alist_pkg::DEF_DATA_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    alist_req_if.sink   i_req,
    alist_rsp_if.source o_rsp
);

    localparam int AW = $clog2(CAPACITY);

    alist_pkg::t_req req;
    alist_pkg::t_rsp res;
    logic            res_valid;
    logic            res_ready;
    logic            req_ready;

    // element store port signals
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr_a;
    logic [AW-1:0]         mem_raddr_b;
    logic [DATA_WIDTH-1:0] mem_rdata_a;
    logic [DATA_WIDTH-1:0] mem_rdata_b;

    // output register
    logic            r_out_valid;
    alist_pkg::t_rsp r_out;

    assign req.kind     = i_req.kind;
    assign req.position = i_req.position;
    assign req.value    = i_req.value;
    assign i_req.ready  = req_ready;

    alist_seq #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req.valid),
        .o_req_ready   (req_ready),
        .i_req         (req),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_raddr_a (mem_raddr_a),
        .o_mem_raddr_b (mem_raddr_b),
        .i_mem_rdata_a (mem_rdata_a),
        .i_mem_rdata_b (mem_rdata_b)
    );

    alist_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (mem_rdata_a),
        .o_rdata_b (mem_rdata_b)
    );

    // register is free when empty or being taken this cycle
    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_value = r_out.read_value;
    assign o_rsp.count      = r_out.count;
    assign o_rsp.status     = r_out.status;

endmodule
